// ----- sv/cds_pkg.sv -----
package cds_pkg;

  localparam int unsigned FpW = 64;
  localparam int unsigned ExpW = 11;
  localparam int unsigned ManW = 52;
  localparam logic [FpW-1:0] PosZero = 64'h0000_0000_0000_0000;
  localparam logic [FpW-1:0] CanonQnan = 64'h7FF8_0000_0000_0000;

  // Unpacked operand: sign, biased exponent, significand with hidden bit
  typedef struct packed {
    logic        sign;
    logic [10:0] exp;
    logic [52:0] sig;
    logic        is_nan;
    logic        is_inf;
  } fp_unp_t;

  function automatic fp_unp_t fp_unpack(input logic [63:0] a);
    fp_unp_t u;
    u.sign   = a[63];
    u.is_nan = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
    u.is_inf = (a[62:52] == 11'h7FF) && (a[51:0] == 52'd0);
    // Subnormals use exponent 1 without the hidden bit
    u.exp = (a[62:52] == 11'd0) ? 11'd1 : a[62:52];
    u.sig = {(a[62:52] != 11'd0), a[51:0]};
    return u;
  endfunction

  // Leading zero count over a 57-bit word
  function automatic logic [5:0] lzc57(input logic [56:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd57;
    found = 1'b0;
    for (int i = 56; i >= 0; i--) begin
      if (!found && v[i]) begin
        n = 6'(56 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  // Double add a + b, round to nearest even, NaN as canonical quiet NaN
  function automatic logic [63:0] fp_add(input logic [63:0] a, input logic [63:0] b);
    fp_unp_t     ua;
    fp_unp_t     ub;
    fp_unp_t     big;
    fp_unp_t     sml;
    logic        swap;
    logic [11:0] dexp;
    logic [55:0] bs;   // sig << 3 : guard, round, sticky room
    logic [55:0] ss;
    logic [55:0] shf;
    logic        stk;
    logic [56:0] sum;
    logic [5:0]  lz;
    logic [12:0] e;
    logic [56:0] nrm;
    logic [12:0] sh;
    logic [52:0] man;
    logic        g;
    logic        r;
    logic        s;
    logic [53:0] rnd;
    logic [63:0] res;
    ua = fp_unpack(a);
    ub = fp_unpack(b);
    swap = ({ub.exp, ub.sig} > {ua.exp, ua.sig});
    big = swap ? ub : ua;
    sml = swap ? ua : ub;
    dexp = {1'b0, big.exp} - {1'b0, sml.exp};
    bs = {big.sig, 3'b000};
    ss = {sml.sig, 3'b000};
    if (dexp >= 12'd56) begin
      shf = 56'd0;
      stk = (ss != 56'd0);
    end else begin
      shf = ss >> dexp[5:0];
      stk = ((ss & ((56'd1 << dexp[5:0]) - 56'd1)) != 56'd0);
    end
    shf[0] = shf[0] | stk;
    if (big.sign == sml.sign) sum = {1'b0, bs} + {1'b0, shf};
    else sum = {1'b0, bs} - {1'b0, shf};
    lz = lzc57(sum);
    // Normalize so the leading one sits at bit 55, capped at the subnormal floor
    e = {2'b00, big.exp} + 13'd1;
    if (sum[56]) begin
      nrm = {1'b0, sum[56:1]} | {56'd0, sum[0]};
      e = e;
    end else begin
      sh = {7'd0, lz} - 13'd1;
      if (sh > e - 13'd2) sh = e - 13'd2;
      nrm = sum << sh[5:0];
      e = e - sh - 13'd1;
    end
    man = nrm[55:3];
    g = nrm[2];
    r = nrm[1];
    s = nrm[0];
    rnd = {1'b0, man} + {53'd0, g & (r | s | man[0])};
    if (rnd[53]) begin
      rnd = {1'b0, rnd[53:1]};
      e = e + 13'd1;
    end
    if (ua.is_nan || ub.is_nan || (ua.is_inf && ub.is_inf && (ua.sign != ub.sign))) begin
      res = CanonQnan;
    end else if (ua.is_inf || ub.is_inf) begin
      res = ua.is_inf ? {ua.sign, 11'h7FF, 52'd0} : {ub.sign, 11'h7FF, 52'd0};
    end else if (sum == 57'd0) begin
      res = {ua.sign & ub.sign, 63'd0};
    end else if (e >= 13'h7FF) begin
      res = {big.sign, 11'h7FF, 52'd0};
    end else begin
      res = {big.sign, (rnd[52] ? e[10:0] : 11'd0), rnd[51:0]};
    end
    return res;
  endfunction

  function automatic logic [63:0] fp_sub(input logic [63:0] a, input logic [63:0] b);
    return fp_add(a, {~b[63], b[62:0]});
  endfunction

endpackage

// ----- sv/compensated_double_sum_unit.sv -----
// Kahan compensated summation of binary64 terms. One term is taken per cycle
// on s_axis (tlast marks the run's final term), but a last term waits while
// a stalled result is pending; the final sum of each run appears on m_axis
// in the cycle after its last term, and state clears for the next run. Four
// chained double adds sit between the state registers, and that path sets the
// clock; a stalled result is held in the output register while non-last terms still enter.
module compensated_double_sum_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // term_bits[63:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // sum_bits[63:0]
);

  logic [63:0] sum_q, sum_d, comp_q, comp_d;
  logic [63:0] y, t, diff;
  logic [63:0] out_q;
  logic        out_vld_q;
  logic        acc;

  // Accept unless the output register is full, not being read, and a last term would overwrite it
  assign s_axis_tready = !(out_vld_q && !m_axis_tready && s_axis_tlast);
  assign acc = s_axis_tvalid && s_axis_tready;

  // Kahan update
  always_comb begin
    y    = cds_pkg::fp_sub(s_axis_tdata, comp_q);
    t    = cds_pkg::fp_add(sum_q, y);
    diff = cds_pkg::fp_sub(t, sum_q);
    sum_d  = sum_q;
    comp_d = comp_q;
    if (acc) begin
      if (s_axis_tlast) begin
        sum_d  = cds_pkg::PosZero;
        comp_d = cds_pkg::PosZero;
      end else begin
        sum_d  = t;
        comp_d = cds_pkg::fp_sub(diff, y);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= cds_pkg::PosZero;
      comp_q    <= cds_pkg::PosZero;
      out_vld_q <= 1'b0;
    end else begin
      sum_q  <= sum_d;
      comp_q <= comp_d;
      if (acc && s_axis_tlast) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (acc && s_axis_tlast) out_q <= t;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && s_axis_tlast) |=> (sum_q == cds_pkg::PosZero && comp_q == cds_pkg::PosZero))
    else $error("state not cleared after run");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("pending result lost");
  a_noover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |-> !(acc && s_axis_tlast))
    else $error("result overwritten");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // term_bits[63:0]
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // sum_bits[63:0]

  compensated_double_sum_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  localparam int unsigned CycleLimit = 200000;

  // Predicted run totals, oldest first
  logic [63:0] sum_queue[$];
  real         run_sum;
  real         run_comp;
  int          n_errors;
  int          n_cycles = 0;
  bit          quiet;

  // Handshake signals sampled mid-cycle, away from the clock edge
  logic s_rdy_n;
  logic m_vld_n;
  logic m_rdy_n;
  logic [63:0] m_dat_n;
  int   stall_left = 0;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    s_rdy_n = s_axis_tready;
    m_vld_n = m_axis_tvalid;
    m_rdy_n = m_axis_tready;
    m_dat_n = m_axis_tdata;
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Binary64 to bits, NaN collapsed to the canonical quiet pattern
  function automatic logic [63:0] to_bits(input real r);
    logic [63:0] b;
    b = $realtobits(r);
    if (b[62:52] == 11'h7FF && b[51:0] != 52'd0) b = cds_pkg::CanonQnan;
    return b;
  endfunction

  // One compensated summation step; returns 1 with the total on the last term
  function automatic bit kahan_step(input logic [63:0] term, input bit last,
                                    output logic [63:0] total);
    real y;
    real t;
    y = $bitstoreal(term) - run_comp;
    t = run_sum + y;
    run_comp = (t - run_sum) - y;
    run_sum = t;
    total = to_bits(run_sum);
    if (last) begin
      run_sum = 0.0;
      run_comp = 0.0;
    end
    return last;
  endfunction

  // Result side: check each transfer, then pick next ready value
  always @(posedge clk_i) begin
    logic [63:0] want;
    if (rst_ni && m_vld_n && m_rdy_n) begin
      if (sum_queue.size() == 0) begin
        $display("%0t: unexpected sum, expected none, actual %h", $realtime, m_dat_n);
        n_errors++;
      end else begin
        want = sum_queue.pop_front();
        if (want !== m_dat_n) begin
          $display("%0t: sum_bits expected %h actual %h", $realtime, want, m_dat_n);
          n_errors++;
        end
      end
    end
    if (quiet || !rst_ni) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(4) == 0) begin
      stall_left = $urandom_range(3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Send one term, with an optional idle burst before it
  task automatic send_term(input logic [63:0] term, input bit last);
    int          gap;
    logic [63:0] total;
    gap = (quiet || $urandom_range(3) != 0) ? 0 : $urandom_range(1, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= term;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_rdy_n);
    if (kahan_step(term, last, total)) sum_queue.insert(sum_queue.size(), total);
  endtask

  // Random term, weighted toward values whose sums exercise compensation
  function automatic logic [63:0] rand_term();
    logic [63:0] b;
    int          kind;
    b = {$urandom, $urandom};
    kind = $urandom_range(19);
    if (kind < 11) b[62:52] = 11'(1023 - 30 + $urandom_range(60));
    else if (kind < 13) b[62:52] = 11'd0;
    else if (kind < 15) b[62:52] = 11'(2040 + $urandom_range(6));
    else if (kind == 15) b[62:0] = 63'd0;
    else if (kind == 16) b = {b[63], 11'h7FF, ($urandom_range(1) ? 52'd0 : b[51:0])};
    return b;
  endfunction

  task automatic test_directed();
    send_term(64'h0000_0000_0000_0000, 1'b1);       // positive zero
    send_term(64'h8000_0000_0000_0000, 1'b1);       // negative zero alone
    send_term(64'h8000_0000_0000_0000, 1'b0);
    send_term(64'h8000_0000_0000_0000, 1'b1);       // -0 + -0
    send_term(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);       // NaN with payload
    send_term(64'h7FF0_0000_0000_0000, 1'b0);       // +inf + -inf
    send_term(64'hFFF0_0000_0000_0000, 1'b1);
    send_term(64'h7FF0_0000_0000_0000, 1'b0);       // inf plus finite
    send_term(64'h3FF0_0000_0000_0000, 1'b1);
    send_term(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);       // overflow, compensation inf
    send_term(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
    send_term(64'h3FF0_0000_0000_0000, 1'b1);
    send_term(64'h0000_0000_0000_0001, 1'b0);       // subnormals kept
    send_term(64'h800F_FFFF_FFFF_FFFF, 1'b0);
    send_term(64'h000F_FFFF_FFFF_FFFF, 1'b1);
    send_term(64'h3FF0_0000_0000_0000, 1'b0);       // small terms recovered
    repeat (6) send_term(64'h3C9C_D2B2_97D8_89BC, 1'b0);
    send_term(64'hBFF0_0000_0000_0000, 1'b1);
  endtask

  task automatic test_random_runs(input int n_items);
    int left;
    int run_len;
    left = n_items;
    while (left > 0) begin
      run_len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      for (int i = 0; i < run_len; i++) send_term(rand_term(), i == run_len - 1);
      left -= run_len;
    end
  endtask

  initial begin
    int wait_cycles;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 64'd0;
    s_axis_tlast  = 1'b0;
    run_sum       = 0.0;
    run_comp      = 0.0;
    n_errors      = 0;
    quiet         = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_runs(1150);
    quiet = 1'b1;
    test_random_runs(180);
    s_axis_tvalid <= 1'b0;

    // Drain the remaining totals, then a short settle
    wait_cycles = 0;
    while (sum_queue.size() != 0 && wait_cycles < 1000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (10) @(posedge clk_i);
    if (n_errors == 0 && sum_queue.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
